### design/heightmap_tile_lighting_unit_defines.svh
`ifndef HEIGHTMAP_TILE_LIGHTING_UNIT_DEFINES_SVH
`define HEIGHTMAP_TILE_LIGHTING_UNIT_DEFINES_SVH
// Assertion helpers
`define HTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/htl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htl_pkg;
    localparam int SqrtSteps = 17;
    localparam int LightDivisor = 213;
    localparam int LightAmbient = 96;
    localparam int NormalBias = 65536;
    localparam int LightX = -50;
    localparam int LightY = -10;
    localparam int LightZ = -50;
    localparam int QuotSteps = 18;

    function automatic logic [8:0] shade_sum(input logic [7:0] c, input logic [7:0] w,
                                             input logic [7:0] e, input logic [7:0] n,
                                             input logic [7:0] s);
        logic [9:0] t;
        t = 10'(c >> 1) + 10'(w >> 2) + 10'(e >> 3) + 10'(n >> 3) + 10'(s >> 2);
        return 9'(t);
    endfunction
endpackage
`default_nettype wire

### design/htl_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module htl_sqrt
    import htl_pkg::*;
#(
    parameter int W = 34,
    parameter int TW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_radicand,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [W/2:0]       o_root,
    output logic [TW-1:0]      o_tag
);
    localparam int S = (W + 1) / 2;
    logic [W+1:0]  r_rem  [0:S];
    logic [W+1:0]  r_rad  [0:S];
    logic [S-1:0]  r_root [0:S];
    logic [TW-1:0] r_tag  [0:S];
    logic [S:0]    r_v;

    always_comb begin
        r_rem[0]  = '0;
        r_rad[0]  = (W + 2)'(i_radicand);
        r_root[0] = '0;
        r_tag[0]  = i_tag;
        r_v[0]    = i_valid;
    end

    for (genvar k = 0; k < S; k++) begin : g_st
        logic [W+1:0] n_rem;
        logic [W+1:0] n_trial;
        logic [S-1:0] n_root;
        always_comb begin
            n_rem   = (r_rem[k] << 2) | (W + 2)'(r_rad[k][2*S-1 -: 2]);
            n_trial = (W + 2)'({r_root[k], 2'b01});
            n_root  = r_root[k] << 1;
            if (n_rem >= n_trial) begin
                n_rem  = n_rem - n_trial;
                n_root = n_root | S'(1);
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_rem;
            r_rad[k+1]  <= r_rad[k] << 2;
            r_root[k+1] <= n_root;
            r_tag[k+1]  <= r_tag[k];
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_root  = (W / 2 + 1)'(r_root[S]);
    assign o_tag   = r_tag[S];
endmodule
`default_nettype wire

### design/htl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module htl_div #(
    parameter int NW = 18,
    parameter int DW = 18,
    parameter int TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [NW-1:0]      o_quot,
    output logic [TW-1:0]      o_tag
);
    logic [DW:0]   r_rem [0:NW];
    logic [NW-1:0] r_num [0:NW];
    logic [DW-1:0] r_den [0:NW];
    logic [TW-1:0] r_tag [0:NW];
    logic [NW:0]   r_v;

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
        r_v[0]   = i_valid;
    end

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [DW:0] n_rem;
        logic        n_q;
        always_comb begin
            n_rem = {r_rem[k][DW-1:0], r_num[k][NW-1]};
            n_q   = (n_rem >= (DW + 1)'(r_den[k]));
            if (n_q) begin
                n_rem = n_rem - (DW + 1)'(r_den[k]);
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_num[k+1] <= {r_num[k][NW-2:0], n_q};
            r_den[k+1] <= r_den[k];
            r_tag[k+1] <= r_tag[k];
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_quot  = r_num[NW];
    assign o_tag   = r_tag[NW];
endmodule
`default_nettype wire

### design/heightmap_tile_lighting_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Tile lighting pipeline. A tile is taken in every cycle (busy is held low) and its light
// value appears on o_light_value with o_valid high exactly once. The pipeline is 2 input
// registers, then (HEIGHT_WIDTH+2) square root stages, then 3 divider banks of HEIGHT_WIDTH+10
// stages each in parallel, then 3 for the dot product and scaling.
// The sink cannot stall, so results must be taken when strobed;
// order is preserved.
module heightmap_tile_lighting_unit
    import htl_pkg::*;
#(
    parameter int HEIGHT_WIDTH = 14
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_edge_tile,
    input  wire logic signed [HEIGHT_WIDTH-1:0] i_height_east,
    input  wire logic signed [HEIGHT_WIDTH-1:0] i_height_west,
    input  wire logic signed [HEIGHT_WIDTH-1:0] i_height_north,
    input  wire logic signed [HEIGHT_WIDTH-1:0] i_height_south,
    input  wire logic [7:0]                     i_shade_center,
    input  wire logic [7:0]                     i_shade_west,
    input  wire logic [7:0]                     i_shade_east,
    input  wire logic [7:0]                     i_shade_north,
    input  wire logic [7:0]                     i_shade_south,
    output logic                                o_valid,
    output logic signed [9:0]                   o_light_value
);
    localparam int DW  = HEIGHT_WIDTH + 1;
    localparam int SQW = 2 * DW + 1;
    localparam int RW  = SQW / 2 + 1;
    localparam int NW  = DW + 9;
    localparam int TW  = 1 + 9 + 2 * DW;
    localparam int QTW = 1 + 9 + 2;

    assign busy = 1'b0;

    logic              r_v0;
    logic              r_edge0;
    logic [8:0]        r_sh0;
    logic signed [DW-1:0] r_dx0;
    logic signed [DW-1:0] r_dz0;
    always_ff @(posedge i_clk) begin
        r_edge0 <= i_edge_tile;
        r_sh0   <= shade_sum(i_shade_center, i_shade_west, i_shade_east,
                             i_shade_north, i_shade_south);
        r_dx0   <= DW'(i_height_east) - DW'(i_height_west);
        r_dz0   <= DW'(i_height_north) - DW'(i_height_south);
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
    end

    logic r_v1;
    logic r_edge1;
    logic [8:0] r_sh1;
    logic signed [DW-1:0] r_dx1;
    logic signed [DW-1:0] r_dz1;
    logic [SQW-1:0] r_sq1;
    always_ff @(posedge i_clk) begin
        r_edge1 <= r_edge0;
        r_sh1   <= r_sh0;
        r_dx1   <= r_dx0;
        r_dz1   <= r_dz0;
        r_sq1   <= SQW'(r_dx0) * SQW'(r_dx0) + SQW'(r_dz0) * SQW'(r_dz0)
                   + SQW'(NormalBias);
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    logic          s_v;
    logic [RW-1:0] s_root;
    logic [TW-1:0] s_tag;
    htl_sqrt #(.W(SQW), .TW(TW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v1), .i_radicand(r_sq1),
        .i_tag({r_edge1, r_sh1, r_dx1, r_dz1}), .o_valid(s_v), .o_root(s_root),
        .o_tag(s_tag)
    );

    logic signed [DW-1:0] s_dx;
    logic signed [DW-1:0] s_dz;
    assign s_dx = s_tag[2*DW-1:DW];
    assign s_dz = s_tag[DW-1:0];

    logic [NW-1:0] ax_num;
    logic [NW-1:0] az_num;
    assign ax_num = {(s_dx[DW-1] ? DW'(-s_dx) : DW'(s_dx)), 8'd0, 1'b0} >> 1;
    assign az_num = {(s_dz[DW-1] ? DW'(-s_dz) : DW'(s_dz)), 8'd0, 1'b0} >> 1;

    logic [QTW-1:0] q_tag;
    assign q_tag = {s_tag[TW-1 -: 10], s_dx[DW-1], s_dz[DW-1]};

    logic          qx_v, qy_v, qz_v;
    logic [NW-1:0] qx, qy, qz;
    logic [QTW-1:0] qx_tag, qy_tag, qz_tag;
    htl_div #(.NW(NW), .DW(RW), .TW(QTW)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_v), .i_num(ax_num), .i_den(s_root),
        .i_tag(q_tag), .o_valid(qx_v), .o_quot(qx), .o_tag(qx_tag)
    );
    htl_div #(.NW(NW), .DW(RW), .TW(QTW)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_v), .i_num(NW'(NormalBias)),
        .i_den(s_root), .i_tag(q_tag), .o_valid(qy_v), .o_quot(qy), .o_tag(qy_tag)
    );
    htl_div #(.NW(NW), .DW(RW), .TW(QTW)) u_divz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_v), .i_num(az_num), .i_den(s_root),
        .i_tag(q_tag), .o_valid(qz_v), .o_quot(qz), .o_tag(qz_tag)
    );

    // quotients are at most 256 in magnitude; dot fits in 17 bits signed
    logic signed [9:0]  n_nx, n_nz;
    logic signed [16:0] r_dot;
    logic        r_v2;
    logic        r_edge2;
    logic [8:0]  r_sh2;
    always_comb begin
        n_nx = qx_tag[1] ? -10'(qx) : 10'(qx);
        n_nz = qx_tag[0] ? -10'(qz) : 10'(qz);
    end
    always_ff @(posedge i_clk) begin
        r_dot   <= 17'(n_nx) * 17'(LightX) + 17'(signed'({1'b0, 9'(qy)})) * 17'(LightY)
                   + 17'(n_nz) * 17'(LightZ);
        r_edge2 <= qx_tag[QTW-1];
        r_sh2   <= qx_tag[QTW-2 -: 9];
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= qx_v & qy_v & qz_v & (qy_tag == qz_tag);
        end
    end

    // truncating divide by constant: magnitude times reciprocal
    logic [15:0] n_mag;
    logic [15:0] r_mag3;
    logic [32:0] r_prod3;
    logic        r_neg3, r_v3, r_edge3;
    logic [8:0]  r_sh3;
    localparam int RecipShift = 24;
    localparam logic [16:0] Recip = 17'(((1 << RecipShift) + LightDivisor - 1) / LightDivisor);
    assign n_mag = r_dot[16] ? 16'(-r_dot) : 16'(r_dot);
    always_ff @(posedge i_clk) begin
        r_prod3 <= n_mag * Recip;
        r_mag3  <= n_mag;
        r_neg3  <= r_dot[16];
        r_edge3 <= r_edge2;
        r_sh3   <= r_sh2;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    logic [7:0]  n_q;
    logic signed [9:0] n_base;
    always_comb begin
        n_q    = 8'(r_prod3 >> RecipShift);
        n_base = (r_neg3 ? -10'(n_q) : 10'(n_q)) + 10'(LightAmbient);
        if (r_edge3) begin
            n_base = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        o_light_value <= n_base - 10'(r_sh3);
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v3;
        end
    end
endmodule
`default_nettype wire

### design/htl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_tile_lighting_unit_defines.svh"
module htl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [9:0] o_light_value
);
    `HTL_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `HTL_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_valid)
    `HTL_ASSERT_IMPL(a_range, i_clk, i_rst_n, o_valid, ($signed(o_light_value) <= 10'sd228) && ($signed(o_light_value) >= -10'sd351))
endmodule
bind heightmap_tile_lighting_unit htl_checker u_htl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_light_value(o_light_value)
);
`default_nettype wire

### tb/tb_heightmap_tile_lighting_unit.sv
`timescale 1ns / 1ps
module tb_heightmap_tile_lighting_unit;
    import htl_pkg::*;

    localparam int HW = 14;
    localparam int N_RANDOM = 1100;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    class light_scoreboard;
        logic signed [9:0] pending_light[$];
        int errors;

        function automatic longint isqrt(longint n);
            longint root;
            longint bitv;
            root = 0;
            bitv = 64'd1 << 40;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function automatic logic signed [9:0] tile_light(logic edge_tile,
                logic signed [HW-1:0] he, logic signed [HW-1:0] hw,
                logic signed [HW-1:0] hn, logic signed [HW-1:0] hs,
                logic [7:0] sc, logic [7:0] sw, logic [7:0] se, logic [7:0] sn,
                logic [7:0] ss);
            longint dx, dz, len, nx, ny, nz, dot, base, shade;
            base = 0;
            if (!edge_tile) begin
                dx = longint'(he) - longint'(hw);
                dz = longint'(hn) - longint'(hs);
                len = isqrt(dx * dx + dz * dz + NormalBias);
                nx = (dx * 256) / len;
                ny = NormalBias / len;
                nz = (dz * 256) / len;
                dot = nx * LightX + ny * LightY + nz * LightZ;
                base = dot / LightDivisor + LightAmbient;
            end
            shade = (sc >> 1) + (sw >> 2) + (se >> 3) + (sn >> 3) + (ss >> 2);
            return 10'(base - shade);
        endfunction

        function void note_tile(logic edge_tile, logic signed [HW-1:0] he,
                logic signed [HW-1:0] hw, logic signed [HW-1:0] hn,
                logic signed [HW-1:0] hs, logic [7:0] sc, logic [7:0] sw,
                logic [7:0] se, logic [7:0] sn, logic [7:0] ss);
            pending_light.push_back(tile_light(edge_tile, he, hw, hn, hs,
                                               sc, sw, se, sn, ss));
        endfunction

        function void check_light(logic signed [9:0] got);
            logic signed [9:0] want;
            if (pending_light.size() == 0) begin
                $error("light_value: unexpected result %0d", got);
                errors++;
            end else begin
                want = pending_light.pop_front();
                if (got !== want) begin
                    $error("light_value: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic i_edge_tile = 0;
    logic signed [HW-1:0] i_height_east = 0, i_height_west = 0;
    logic signed [HW-1:0] i_height_north = 0, i_height_south = 0;
    logic [7:0] i_shade_center = 0, i_shade_west = 0, i_shade_east = 0;
    logic [7:0] i_shade_north = 0, i_shade_south = 0;
    logic o_valid;
    logic signed [9:0] o_light_value;

    light_scoreboard sb;
    int idle_cycles;
    bit gaps_on;

    heightmap_tile_lighting_unit #(.HEIGHT_WIDTH(HW)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_edge_tile(i_edge_tile),
        .i_height_east(i_height_east), .i_height_west(i_height_west),
        .i_height_north(i_height_north), .i_height_south(i_height_south),
        .i_shade_center(i_shade_center), .i_shade_west(i_shade_west),
        .i_shade_east(i_shade_east), .i_shade_north(i_shade_north),
        .i_shade_south(i_shade_south),
        .o_valid(o_valid), .o_light_value(o_light_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_light(o_light_value);
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one transfer; start stays high if the next tile follows at once
    task automatic send_tile(logic e, logic signed [HW-1:0] he, logic signed [HW-1:0] hw,
                             logic signed [HW-1:0] hn, logic signed [HW-1:0] hs,
                             logic [7:0] sc, logic [7:0] sw, logic [7:0] se,
                             logic [7:0] sn, logic [7:0] ss);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_edge_tile <= e;
        i_height_east <= he; i_height_west <= hw;
        i_height_north <= hn; i_height_south <= hs;
        i_shade_center <= sc; i_shade_west <= sw; i_shade_east <= se;
        i_shade_north <= sn; i_shade_south <= ss;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_tile(e, he, hw, hn, hs, sc, sw, se, sn, ss);
    endtask

    task automatic send_random_tile();
        logic signed [HW-1:0] h0;
        int span;
        h0 = HW'($urandom);
        span = $urandom_range(0, 3);
        if (span == 0) begin
            send_tile($urandom_range(0, 7) == 0, HW'($urandom), HW'($urandom),
                      HW'($urandom), HW'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            // realistic terrain: neighbours near one another
            send_tile($urandom_range(0, 7) == 0,
                      h0 + HW'($urandom_range(0, 1024)) - HW'(512),
                      h0 + HW'($urandom_range(0, 1024)) - HW'(512),
                      h0 + HW'($urandom_range(0, 64)) - HW'(32),
                      h0 + HW'($urandom_range(0, 64)) - HW'(32),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        end
    endtask

    localparam logic signed [HW-1:0] HMAX = {1'b0, {(HW-1){1'b1}}};
    localparam logic signed [HW-1:0] HMIN = {1'b1, {(HW-1){1'b0}}};

    initial begin
        sb = new();
        idle_cycles = 0;
        gaps_on = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_tile(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tile(0, HMAX, HMIN, HMAX, HMIN, 0, 0, 0, 0, 0);
        send_tile(0, HMIN, HMAX, HMIN, HMAX, 0, 0, 0, 0, 0);
        send_tile(0, HMAX, HMIN, HMIN, HMAX, 255, 255, 255, 255, 255);
        send_tile(0, HMIN, HMAX, HMAX, HMIN, 255, 255, 255, 255, 255);
        send_tile(0, HMAX, HMIN, 0, 0, 255, 0, 0, 0, 0);
        send_tile(0, 0, 0, HMAX, HMIN, 0, 255, 0, 0, 0);
        send_tile(0, -1, 0, 0, -1, 0, 0, 255, 0, 0);
        send_tile(0, 100, -100, 50, -50, 0, 0, 0, 255, 0);
        send_tile(0, -100, 100, -50, 50, 0, 0, 0, 0, 255);
        send_tile(1, HMAX, HMIN, HMAX, HMIN, 0, 0, 0, 0, 0);
        send_tile(1, 0, 0, 0, 0, 255, 255, 255, 255, 255);
        send_tile(1, HMIN, HMIN, HMIN, HMIN, 1, 3, 7, 7, 3);
        send_tile(0, 256, 0, 0, 256, 170, 85, 170, 85, 170);
        send_tile(0, -256, 0, 0, -256, 85, 170, 85, 170, 85);
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k >= N_RANDOM - 150) gaps_on = 0;
            send_random_tile();
        end
        start <= 0;
        while (sb.pending_light.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
